@@ rtl/ltf_pkg.sv @@
// Shared types and constants for the layered linear texture fetch core.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package ltf_pkg;

    // Item kind carried on the slave tuser bit
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_FETCH = 1'b1;

    // Configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ROW_WIDTH   = 2'd0;
    localparam t_cfg_idx CFG_LAYER_COUNT = 2'd1;
    localparam t_cfg_idx CFG_HW_MODE     = 2'd2;

    localparam int CFG_DATA_W      = 11;
    localparam int ROW_WIDTH_RST   = 1024;

    // Field widths fixed by the stream format
    localparam int TEXEL_W      = 32;
    localparam int LAYER_FLD_W  = 4;
    localparam int INDEX_FLD_W  = 10;
    localparam int LAYCNT_FLD_W = 5;
    localparam int S_TDATA_W    = 112;

    // Output queue that decouples the pipeline from the master side
    localparam int OFIFO_DEPTH = 8;
    localparam int OFIFO_PTR_W = 3;
    localparam int OFIFO_CNT_W = 4;

    // Control that travels with an item from the address stage
    typedef struct packed {
        logic fetch;
        logic write;
    } t_mem_ctl;

endpackage

@@ rtl/ltf_addr.sv @@
// Address and weight stage: configuration registers, coordinate clamp and split,
// layer rounding, load range check. Depends on ltf_pkg.
module ltf_addr #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_LAYERS = 16,
    parameter int FRAC_BITS  = 16,
    localparam int IDX_W = $clog2(MAX_WIDTH),
    localparam int LAY_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1,
    localparam int WW    = FRAC_BITS + 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  ltf_pkg::t_cfg_idx                   i_cfg_index,
    input  logic [ltf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_accept,
    input  logic                                i_kind,
    input  logic [ltf_pkg::LAYER_FLD_W-1:0]     i_texel_layer,
    input  logic [ltf_pkg::INDEX_FLD_W-1:0]     i_texel_index,
    input  logic [ltf_pkg::TEXEL_W-1:0]         i_texel_value,
    input  logic [31:0]                         i_coord,
    input  logic [31:0]                         i_layer_coord,
    output ltf_pkg::t_mem_ctl                   o_ctl,
    output logic [LAY_W-1:0]                    o_layer,
    output logic [IDX_W-1:0]                    o_idx0,
    output logic [IDX_W-1:0]                    o_idx1,
    output logic [WW-1:0]                       o_weight,
    output logic [ltf_pkg::TEXEL_W-1:0]         o_wdata
);
    localparam int UW   = (IDX_W + FRAC_BITS > 31) ? IDX_W + FRAC_BITS : 31;
    localparam int LQW  = 33 - FRAC_BITS;
    localparam int LCW  = (LQW > LAY_W) ? LQW : LAY_W;
    localparam int RST_WM1 = ((ltf_pkg::ROW_WIDTH_RST > MAX_WIDTH) ?
                              MAX_WIDTH : ltf_pkg::ROW_WIDTH_RST) - 1;

    // Configuration held in its clamped form: last index and last layer
    logic [IDX_W-1:0] r_wm1, n_wm1;
    logic [LAY_W-1:0] r_lm1, n_lm1;
    logic             r_hw,  n_hw;

    logic [10:0] cfg_rw;
    logic [4:0]  cfg_lc;

    always_comb begin
        cfg_rw = i_cfg_data;
        cfg_lc = i_cfg_data[ltf_pkg::LAYCNT_FLD_W-1:0];
        n_wm1  = r_wm1;
        n_lm1  = r_lm1;
        n_hw   = r_hw;
        if (i_cfg_we) begin
            case (i_cfg_index)
                ltf_pkg::CFG_ROW_WIDTH: begin
                    if (cfg_rw == 11'd0) begin
                        n_wm1 = '0;
                    end else if (32'(cfg_rw) > 32'(MAX_WIDTH)) begin
                        n_wm1 = IDX_W'(MAX_WIDTH - 1);
                    end else begin
                        n_wm1 = IDX_W'(cfg_rw - 11'd1);
                    end
                end
                ltf_pkg::CFG_LAYER_COUNT: begin
                    if (cfg_lc == 5'd0) begin
                        n_lm1 = '0;
                    end else if (32'(cfg_lc) > 32'(MAX_LAYERS)) begin
                        n_lm1 = LAY_W'(MAX_LAYERS - 1);
                    end else begin
                        n_lm1 = LAY_W'(cfg_lc - 5'd1);
                    end
                end
                ltf_pkg::CFG_HW_MODE: begin
                    n_hw = i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wm1 <= IDX_W'(RST_WM1);
            r_lm1 <= '0;
            r_hw  <= 1'b0;
        end else begin
            r_wm1 <= n_wm1;
            r_lm1 <= n_lm1;
            r_hw  <= n_hw;
        end
    end

    // Coordinate clamp to 0..(w-1) and split into index and fraction
    logic [UW-1:0]        upos, wmax, uc;
    logic [IDX_W-1:0]     j0, j1;
    logic [FRAC_BITS-1:0] fw;
    logic [FRAC_BITS+1:0] hw_sum;
    logic [WW-1:0]        weight;
    logic [32:0]          lv;
    logic [LQW-1:0]       lq;
    logic [LAY_W-1:0]     layer;
    logic                 load_ok;

    always_comb begin
        upos = UW'(i_coord[30:0]);
        wmax = UW'(r_wm1) << FRAC_BITS;
        if (i_coord[31]) begin
            uc = '0;
        end else if (upos > wmax) begin
            uc = wmax;
        end else begin
            uc = upos;
        end
        j0 = IDX_W'(uc >> FRAC_BITS);
        fw = uc[FRAC_BITS-1:0];
        j1 = (j0 < r_wm1) ? j0 + IDX_W'(1) : j0;

        // Round the fraction half up to 8 bits; may become exactly 1.0
        hw_sum = {1'b0, fw, 1'b0} + ((FRAC_BITS+2)'(1) << (FRAC_BITS - 8));
        if (r_hw) begin
            weight = WW'((hw_sum >> (FRAC_BITS - 7)) << (FRAC_BITS - 8));
        end else begin
            weight = {1'b0, fw};
        end

        // Layer: add one half, floor, clamp
        lv = {i_layer_coord[31], i_layer_coord} + (33'd1 << (FRAC_BITS - 1));
        lq = lv[32:FRAC_BITS];
        if (lv[32]) begin
            layer = '0;
        end else if (LCW'(lq) > LCW'(r_lm1)) begin
            layer = r_lm1;
        end else begin
            layer = LAY_W'(lq);
        end

        load_ok = (32'(i_texel_layer) < 32'(MAX_LAYERS)) &&
                  (32'(i_texel_index) < 32'(MAX_WIDTH));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else begin
            o_ctl.fetch <= i_accept && (i_kind == ltf_pkg::KIND_FETCH);
            o_ctl.write <= i_accept && (i_kind == ltf_pkg::KIND_LOAD) && load_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_kind == ltf_pkg::KIND_FETCH) begin
            o_layer <= layer;
            o_idx0  <= j0;
        end else begin
            o_layer <= LAY_W'(i_texel_layer);
            o_idx0  <= IDX_W'(i_texel_index);
        end
        o_idx1   <= j1;
        o_weight <= weight;
        o_wdata  <= i_texel_value;
    end

endmodule

@@ rtl/ltf_texel_mem.sv @@
// Texel store: one write port and two registered read ports, addressed by
// layer*MAX_WIDTH + index. Depends on ltf_pkg.
module ltf_texel_mem #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_LAYERS = 16,
    localparam int IDX_W = $clog2(MAX_WIDTH),
    localparam int LAY_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1
) (
    input  logic                         i_clk,
    input  ltf_pkg::t_mem_ctl            i_ctl,
    input  logic [LAY_W-1:0]             i_layer,
    input  logic [IDX_W-1:0]             i_idx0,
    input  logic [IDX_W-1:0]             i_idx1,
    input  logic [ltf_pkg::TEXEL_W-1:0]  i_wdata,
    output logic [ltf_pkg::TEXEL_W-1:0]  o_rd0,
    output logic [ltf_pkg::TEXEL_W-1:0]  o_rd1
);
    localparam int DEPTH  = MAX_WIDTH * MAX_LAYERS;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [ltf_pkg::TEXEL_W-1:0] r_mem [DEPTH];
    logic [ADDR_W-1:0]           base, addr0, addr1;

    always_comb begin
        base  = ADDR_W'(i_layer) * ADDR_W'(MAX_WIDTH);
        addr0 = base + ADDR_W'(i_idx0);
        addr1 = base + ADDR_W'(i_idx1);
    end

    // Loads use port 0's address for the write
    always_ff @(posedge i_clk) begin
        if (i_ctl.write) begin
            r_mem[addr0] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd0 <= r_mem[addr0];
        o_rd1 <= r_mem[addr1];
    end

endmodule

@@ rtl/ltf_lerp.sv @@
// Interpolation pipeline: difference, weight multiply, floor shift and add.
// Depends on ltf_pkg.
module ltf_lerp #(
    parameter int FRAC_BITS = 16,
    localparam int WW = FRAC_BITS + 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ltf_pkg::t_mem_ctl            i_ctl,
    input  logic [WW-1:0]                i_weight,
    input  logic [ltf_pkg::TEXEL_W-1:0]  i_a,
    input  logic [ltf_pkg::TEXEL_W-1:0]  i_b,
    output logic                         o_valid,
    output logic [ltf_pkg::TEXEL_W-1:0]  o_result
);
    localparam int PW = FRAC_BITS + 35;

    // Stage alongside the memory read
    logic          r_m_vld;
    logic [WW-1:0] r_m_w;
    // Difference stage
    logic                        r_d_vld;
    logic [WW-1:0]               r_d_w;
    logic [ltf_pkg::TEXEL_W-1:0] r_d_a;
    logic signed [32:0]          r_d_diff;
    // Product stage
    logic                        r_p_vld;
    logic [ltf_pkg::TEXEL_W-1:0] r_p_a;
    logic signed [PW-1:0]        r_p_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_p_vld <= 1'b0;
        end else begin
            r_m_vld <= i_ctl.fetch;
            r_d_vld <= r_m_vld;
            r_p_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_w    <= i_weight;
        r_d_w    <= r_m_w;
        r_d_a    <= i_a;
        r_d_diff <= $signed({i_b[31], i_b}) - $signed({i_a[31], i_a});
        r_p_a    <= r_d_a;
        r_p_prod <= $signed({1'b0, r_d_w}) * r_d_diff;
    end

    // Arithmetic shift floors the product; the sum stays between a and b
    assign o_valid  = r_p_vld;
    assign o_result = r_p_a + ltf_pkg::TEXEL_W'(r_p_prod >>> FRAC_BITS);

endmodule

@@ rtl/ltf_out_fifo.sv @@
// Result queue between the interpolation pipeline and the master stream side.
// Depends on ltf_pkg.
module ltf_out_fifo (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr_en,
    input  logic [ltf_pkg::TEXEL_W-1:0]  i_wr_data,
    output logic                         o_tvalid,
    input  logic                         i_tready,
    output logic [ltf_pkg::TEXEL_W-1:0]  o_tdata
);
    logic [ltf_pkg::TEXEL_W-1:0]     r_mem [ltf_pkg::OFIFO_DEPTH];
    logic [ltf_pkg::OFIFO_PTR_W-1:0] r_wptr, r_rptr;
    logic [ltf_pkg::OFIFO_CNT_W-1:0] r_cnt, n_cnt;
    logic                            rd_en;

    assign o_tvalid = (r_cnt != '0);
    assign o_tdata  = r_mem[r_rptr];
    assign rd_en    = o_tvalid && i_tready;

    always_comb begin
        n_cnt = r_cnt;
        if (i_wr_en && !rd_en) begin
            n_cnt = r_cnt + ltf_pkg::OFIFO_CNT_W'(1);
        end else if (!i_wr_en && rd_en) begin
            n_cnt = r_cnt - ltf_pkg::OFIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_wr_en) begin
                r_wptr <= r_wptr + ltf_pkg::OFIFO_PTR_W'(1);
            end
            if (rd_en) begin
                r_rptr <= r_rptr + ltf_pkg::OFIFO_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wptr] <= i_wr_data;
        end
    end

endmodule

@@ rtl/layered_texture_linear_fetch_core.sv @@
// Layered 1D texture fetch with linear filtering; top level over ltf_addr,
// ltf_texel_mem, ltf_lerp and ltf_out_fifo. Depends on ltf_pkg.
// Throughput: one item (load or fetch) per cycle; the slave side stalls only while eight
//   fetch results are outstanding, which happens when the master side holds tready low.
// Path: a fetch result passes the address stage, the memory read, the difference and
//   product stages and the output queue to the master side. Loads produce no result.
// Reset: clears control and configuration (row width 1024, one layer, full weight);
//   the texel memory is not cleared and holds nothing meaningful until loaded.
module layered_texture_linear_fetch_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_LAYERS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  ltf_pkg::t_cfg_idx                  i_cfg_index,
    input  logic [ltf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Slave stream: items in
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // tdata: texel_layer[3:0], texel_index[13:4], texel_value[45:14],
    //        coord[77:46], layer_coord[109:78], zero fill[111:110]
    input  logic [ltf_pkg::S_TDATA_W-1:0]      i_s_axis_tdata,
    // tuser: kind[0]
    input  logic                               i_s_axis_tuser,
    // Master stream: results out
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // tdata: sample_value[31:0]
    output logic [ltf_pkg::TEXEL_W-1:0]        o_m_axis_tdata
);
    localparam int IDX_W = $clog2(MAX_WIDTH);
    localparam int LAY_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int WW    = FRAC_BITS + 1;

    // Configuration is taken at any time; the user writes it only while idle
    assign o_cfg_ready = 1'b1;

    logic cfg_we;
    logic in_acc, in_fetch, out_hs;

    assign cfg_we   = i_cfg_valid && o_cfg_ready;
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign in_fetch = in_acc && (i_s_axis_tuser == ltf_pkg::KIND_FETCH);
    assign out_hs   = o_m_axis_tvalid && i_m_axis_tready;

    // Output queue credits: every accepted fetch reserves a slot until its result
    // leaves, so the pipeline never has to stall and the queue never overflows.
    logic [ltf_pkg::OFIFO_CNT_W-1:0] r_used, n_used;

    always_comb begin
        n_used = r_used;
        if (in_fetch && !out_hs) begin
            n_used = r_used + ltf_pkg::OFIFO_CNT_W'(1);
        end else if (!in_fetch && out_hs) begin
            n_used = r_used - ltf_pkg::OFIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= n_used;
        end
    end

    assign o_s_axis_tready = (r_used < ltf_pkg::OFIFO_CNT_W'(ltf_pkg::OFIFO_DEPTH));

    // Address stage
    ltf_pkg::t_mem_ctl           s2_ctl;
    logic [LAY_W-1:0]            s2_layer;
    logic [IDX_W-1:0]            s2_idx0, s2_idx1;
    logic [WW-1:0]               s2_weight;
    logic [ltf_pkg::TEXEL_W-1:0] s2_wdata;

    ltf_addr #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_LAYERS (MAX_LAYERS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_addr (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (in_acc),
        .i_kind        (i_s_axis_tuser),
        .i_texel_layer (i_s_axis_tdata[3:0]),
        .i_texel_index (i_s_axis_tdata[13:4]),
        .i_texel_value (i_s_axis_tdata[45:14]),
        .i_coord       (i_s_axis_tdata[77:46]),
        .i_layer_coord (i_s_axis_tdata[109:78]),
        .o_ctl         (s2_ctl),
        .o_layer       (s2_layer),
        .o_idx0        (s2_idx0),
        .o_idx1        (s2_idx1),
        .o_weight      (s2_weight),
        .o_wdata       (s2_wdata)
    );

    // Texel store: loads and fetches pass the same stage in order, so a fetch
    // always sees every load accepted before it without forwarding.
    logic [ltf_pkg::TEXEL_W-1:0] tex_a, tex_b;

    ltf_texel_mem #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_LAYERS (MAX_LAYERS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (s2_ctl),
        .i_layer (s2_layer),
        .i_idx0  (s2_idx0),
        .i_idx1  (s2_idx1),
        .i_wdata (s2_wdata),
        .o_rd0   (tex_a),
        .o_rd1   (tex_b)
    );

    // Interpolation
    logic                        res_vld;
    logic [ltf_pkg::TEXEL_W-1:0] res_val;

    ltf_lerp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lerp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (s2_ctl),
        .i_weight (s2_weight),
        .i_a      (tex_a),
        .i_b      (tex_b),
        .o_valid  (res_vld),
        .o_result (res_val)
    );

    // Hold results until the master side takes them
    ltf_out_fifo u_ofifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (res_vld),
        .i_wr_data (res_val),
        .o_tvalid  (o_m_axis_tvalid),
        .i_tready  (i_m_axis_tready),
        .o_tdata   (o_m_axis_tdata)
    );

endmodule

@@ tb/tb_layered_texture_linear_fetch_core.sv @@
// Self-checking testbench for layered_texture_linear_fetch_core: a directed table, then random
// load/fetch traffic checked against a behavioral interpolator kept inside this file.
// Depends on ltf_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_layered_texture_linear_fetch_core;

    localparam int ROW_SLOTS   = 1024;   // MAX_WIDTH of the instance
    localparam int LAYER_SLOTS = 16;     // MAX_LAYERS of the instance
    localparam int FRAC_W      = 16;
    localparam int DRAIN_CYCLES = 8;     // pipeline latency plus margin for trailing loads

    typedef enum logic [1:0] {
        ROW_LOAD,
        ROW_FETCH,
        ROW_CFG
    } t_row_kind;

    // One line of the directed table; want is used only when typed is set
    typedef struct packed {
        t_row_kind          op;
        ltf_pkg::t_cfg_idx  reg_idx;
        logic [10:0]        reg_data;
        logic [3:0]         lyr;
        logic [9:0]         idx;
        logic [31:0]        val;
        logic [31:0]        crd;
        logic [31:0]        lcrd;
        logic               typed;
        logic [31:0]        want;
    } t_test_row;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    ltf_pkg::t_cfg_idx                  i_cfg_index = ltf_pkg::CFG_ROW_WIDTH;
    logic [ltf_pkg::CFG_DATA_W-1:0]     i_cfg_data = '0;
    logic                               i_s_axis_tvalid = 1'b0;
    logic                               o_s_axis_tready;
    logic [ltf_pkg::S_TDATA_W-1:0]      i_s_axis_tdata = '0;
    logic                               i_s_axis_tuser = ltf_pkg::KIND_LOAD;
    logic                               o_m_axis_tvalid;
    logic                               i_m_axis_tready = 1'b0;
    logic [ltf_pkg::TEXEL_W-1:0]        o_m_axis_tdata;

    // Shadow of the texel memory and of the configuration, as the core should hold them
    logic [31:0]    texel_mem [0:ROW_SLOTS*LAYER_SLOTS-1];
    bit             texel_written [0:ROW_SLOTS*LAYER_SLOTS-1];
    logic [10:0]    cfg_row_width = 11'd1024;
    logic [4:0]     cfg_layer_count = 5'd1;
    logic           cfg_hw_mode = 1'b0;

    logic [31:0]    pending_samples [$];
    logic [31:0]    sample_due;
    int             mismatch_count = 0;
    int             items_sent = 0;
    int             send_gap_pct = 27;
    int             recv_stall_pct = 60;

    t_test_row      directed_plan [25];

    layered_texture_linear_fetch_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hard stop in case the core hangs a handshake
    initial begin
        #(2_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    // ---------------------------------------------------------------------------------------
    // Behavioral interpolator
    // ---------------------------------------------------------------------------------------

    // Register values outside the legal range clamp: zero acts as one, large acts as the max
    function automatic int eff_width();
        int w;
        w = int'(cfg_row_width);
        if (w < 1) w = 1;
        if (w > ROW_SLOTS) w = ROW_SLOTS;
        return w;
    endfunction

    function automatic int eff_layers();
        int lc;
        lc = int'(cfg_layer_count);
        if (lc < 1) lc = 1;
        if (lc > LAYER_SLOTS) lc = LAYER_SLOTS;
        return lc;
    endfunction

    // Resolve a fetch into its two texel positions, its layer and its raw 16-bit weight
    function automatic void locate_taps(input logic [31:0] crd, input logic [31:0] lcrd,
                                        output int j0, output int j1, output int lyr,
                                        output longint frac);
        int w;
        int lc;
        longint u;
        longint lv;
        longint umax;
        w = eff_width();
        lc = eff_layers();
        umax = (longint'(w) - 1) * (longint'(1) << FRAC_W);
        u = longint'($signed(crd));
        if (u < 0) u = 0;
        if (u > umax) u = umax;
        j0 = int'(u >> FRAC_W);
        frac = u & ((longint'(1) << FRAC_W) - 1);
        j1 = (j0 + 1 < w) ? j0 + 1 : w - 1;
        // round the layer half up, then clamp at both ends
        lv = longint'($signed(lcrd)) + (longint'(1) << (FRAC_W - 1));
        lyr = (lv < 0) ? 0 : int'(lv >> FRAC_W);
        if (lyr > lc - 1) lyr = lc - 1;
    endfunction

    function automatic logic [31:0] predict_sample(input logic [31:0] crd, input logic [31:0] lcrd);
        int j0;
        int j1;
        int lyr;
        longint frac;
        longint a;
        longint b;
        longint res;
        locate_taps(crd, lcrd, j0, j1, lyr, frac);
        // hardware weight: round to 8 fractional bits; may land exactly on 1.0
        if (cfg_hw_mode) frac = (((frac << 1) + 256) >> 9) << 8;
        a = longint'($signed(texel_mem[lyr * ROW_SLOTS + j0]));
        b = longint'($signed(texel_mem[lyr * ROW_SLOTS + j1]));
        res = a + ((frac * (b - a)) >>> FRAC_W);
        return res[31:0];
    endfunction

    // ---------------------------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------------------------

    // tdata fields from bit 0 up: layer, index, value, coord, layer coord, two zero bits
    function automatic logic [111:0] pack_item(input logic [3:0] lyr, input logic [9:0] idx,
                                               input logic [31:0] val, input logic [31:0] crd,
                                               input logic [31:0] lcrd);
        return {2'b00, lcrd, crd, val, idx, lyr};
    endfunction

    // Mostly full-range texels, some small ones so that differences stay modest
    function automatic logic [31:0] rand_texel();
        if ($urandom_range(3) != 0) return $urandom();
        return $urandom_range(32'h3_FFFF) - 32'h2_0000;
    endfunction

    function automatic t_test_row row_load(input logic [3:0] lyr, input logic [9:0] idx,
                                           input logic [31:0] val);
        t_test_row r;
        r = '0;
        r.op = ROW_LOAD;
        r.lyr = lyr;
        r.idx = idx;
        r.val = val;
        return r;
    endfunction

    function automatic t_test_row row_fetch(input logic [31:0] crd, input logic [31:0] lcrd,
                                            input logic typed, input logic [31:0] want);
        t_test_row r;
        r = '0;
        r.op = ROW_FETCH;
        r.crd = crd;
        r.lcrd = lcrd;
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    function automatic t_test_row row_cfg(input ltf_pkg::t_cfg_idx ridx, input logic [10:0] rdata);
        t_test_row r;
        r = '0;
        r.op = ROW_CFG;
        r.reg_idx = ridx;
        r.reg_data = rdata;
        return r;
    endfunction

    // Present one item, hold it until accepted, then advance the shadow state.
    // A typed expectation replaces the predicted one for that fetch.
    task automatic send_item(input logic kind, input logic [111:0] data,
                             input logic typed, input logic [31:0] want);
        while ($urandom_range(99) < send_gap_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= data;
        i_s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_axis_tready);
        items_sent++;
        if (kind == ltf_pkg::KIND_LOAD) begin
            texel_mem[{data[3:0], data[13:4]}]     = data[45:14];
            texel_written[{data[3:0], data[13:4]}] = 1'b1;
        end else begin
            pending_samples.push_back(typed ? want : predict_sample(data[77:46], data[109:78]));
        end
    endtask

    // Hold the sender until every result is back, then let trailing loads clear the pipe
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input ltf_pkg::t_cfg_idx ridx, input logic [10:0] rdata);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= ridx;
        i_cfg_data  <= rdata;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (ridx)
            ltf_pkg::CFG_ROW_WIDTH:   cfg_row_width = rdata;
            ltf_pkg::CFG_LAYER_COUNT: cfg_layer_count = rdata[4:0];
            ltf_pkg::CFG_HW_MODE:     cfg_hw_mode = rdata[0];
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------------------------------
    // Result side: random stalls, in-order compare against the oldest expectation
    // ---------------------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_samples.size() == 0) begin
                    $error("sample_value: no result expected, got %h", o_m_axis_tdata);
                    mismatch_count++;
                end else begin
                    sample_due = pending_samples.pop_front();
                    if (o_m_axis_tdata !== sample_due) begin
                        $error("sample_value mismatch: expected %h, got %h",
                               sample_due, o_m_axis_tdata);
                        mismatch_count++;
                    end
                end
            end
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------------------------
    initial begin
        int w;
        int lc;
        int j0;
        int j1;
        int lyr;
        int seg_stop;
        longint frac;
        logic [31:0] crd;
        logic [31:0] lcrd;
        logic [10:0] width_val;
        logic [10:0] layers_val;

        // Directed table; starts from the reset configuration (1024 wide, one layer, full weight)
        directed_plan[0]  = row_load(4'd0, 10'd0, 32'h7FFF_FFFF);
        directed_plan[1]  = row_load(4'd0, 10'd1, 32'h8000_0000);
        directed_plan[2]  = row_load(4'd0, 10'd1023, 32'h1234_5678);
        directed_plan[3]  = row_fetch(32'h0000_0000, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF);
        // negative coordinate and negative layer both clamp to zero
        directed_plan[4]  = row_fetch(32'h8000_0000, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF);
        // coordinate past the row end pins to the last texel; its neighbor is itself
        directed_plan[5]  = row_fetch(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h1234_5678);
        // widest possible difference at half weight: the floored product brings the sum to minus one
        directed_plan[6]  = row_fetch(32'h0000_8000, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF);
        directed_plan[7]  = row_fetch(32'h0000_FFFF, 32'h0000_0000, 1'b0, '0);
        directed_plan[8]  = row_cfg(ltf_pkg::CFG_LAYER_COUNT, 11'd16);
        directed_plan[9]  = row_load(4'd1, 10'd0, 32'h0001_0000);
        directed_plan[10] = row_load(4'd1, 10'd1, 32'h0003_0000);
        directed_plan[11] = row_load(4'd15, 10'd0, 32'hAAAA_5555);
        directed_plan[12] = row_load(4'd15, 10'd1, 32'h5555_AAAA);
        // layer coordinate exactly at one half rounds up
        directed_plan[13] = row_fetch(32'h0000_8000, 32'h0000_8000, 1'b1, 32'h0002_0000);
        directed_plan[14] = row_fetch(32'h0000_8000, 32'h0000_7FFF, 1'b1, 32'hFFFF_FFFF);
        directed_plan[15] = row_fetch(32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 32'hAAAA_5555);
        directed_plan[16] = row_cfg(ltf_pkg::CFG_HW_MODE, 11'd1);
        // hardware weight rounds up to a full 1.0 and returns the right texel
        directed_plan[17] = row_fetch(32'h0000_FFC0, 32'h0001_0000, 1'b1, 32'h0003_0000);
        directed_plan[18] = row_fetch(32'h0000_FF7F, 32'h0001_0000, 1'b1, 32'h0002_FE00);
        // zero width acts as a single texel
        directed_plan[19] = row_cfg(ltf_pkg::CFG_ROW_WIDTH, 11'd0);
        directed_plan[20] = row_fetch(32'h0005_0000, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF);
        // oversized width clamps to the full row, zero layers acts as one
        directed_plan[21] = row_cfg(ltf_pkg::CFG_ROW_WIDTH, 11'd2047);
        directed_plan[22] = row_cfg(ltf_pkg::CFG_LAYER_COUNT, 11'd0);
        directed_plan[23] = row_cfg(ltf_pkg::CFG_HW_MODE, 11'd0);
        directed_plan[24] = row_fetch(32'h7FFF_FFFF, 32'h0010_0000, 1'b1, 32'h1234_5678);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[r]) begin
            case (directed_plan[r].op)
                ROW_LOAD: send_item(ltf_pkg::KIND_LOAD,
                                    pack_item(directed_plan[r].lyr, directed_plan[r].idx,
                                              directed_plan[r].val, '0, '0), 1'b0, '0);
                ROW_FETCH: send_item(ltf_pkg::KIND_FETCH,
                                     pack_item('0, '0, '0, directed_plan[r].crd,
                                               directed_plan[r].lcrd),
                                     directed_plan[r].typed, directed_plan[r].want);
                default: write_register(directed_plan[r].reg_idx, directed_plan[r].reg_data);
            endcase
        end

        // Random part: six segments, each with its own settings; pairs of segments share an idle profile.
        // Every register write drains the core first, so the sender pauses for all results.
        for (int seg = 0; seg < 6; seg++) begin
            case (seg)
                0: begin width_val = 11'd8;    layers_val = 11'd16; end
                1: begin width_val = 11'd1024; layers_val = 11'd3;  end
                2: begin width_val = 11'd1;    layers_val = 11'd31; end
                3: begin width_val = 11'd2;    layers_val = 11'd1;  end
                4: begin
                    width_val  = 11'($urandom_range(1023, 3));
                    layers_val = 11'($urandom_range(16, 1));
                end
                default: begin
                    width_val  = 11'($urandom_range(2047, 1025));
                    layers_val = 11'd0;
                end
            endcase
            write_register(ltf_pkg::CFG_ROW_WIDTH, width_val);
            write_register(ltf_pkg::CFG_LAYER_COUNT, layers_val);
            write_register(ltf_pkg::CFG_HW_MODE, 11'(seg % 2));
            // receiver stalls more than sender idles, then the reverse, then neither idles
            send_gap_pct   = (seg < 2) ? 27 : (seg < 4) ? 60 : 0;
            recv_stall_pct = (seg < 2) ? 60 : (seg < 4) ? 27 : 0;

            w = eff_width();
            lc = eff_layers();
            seg_stop = items_sent + 188;
            while (items_sent < seg_stop) begin
                if ($urandom_range(99) < 30) begin
                    // stray load, sometimes outside the rows and layers in use
                    lyr = $urandom_range(1) ? $urandom_range(15) : $urandom_range(lc - 1);
                    j0  = $urandom_range(1) ? $urandom_range(1023) : $urandom_range(w - 1);
                    send_item(ltf_pkg::KIND_LOAD,
                              pack_item(lyr[3:0], j0[9:0], rand_texel(), $urandom(), $urandom()),
                              1'b0, '0);
                end else begin
                    case ($urandom_range(9))
                        0: crd = $urandom();
                        1: crd = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                        default: crd = ($urandom_range(w - 1) << 16) | $urandom_range(16'hFFFF);
                    endcase
                    if ($urandom_range(7) == 0) begin
                        lcrd = $urandom();
                    end else begin
                        lcrd = ($urandom_range(lc) << 16) + $urandom_range(16'hFFFF) - 32'h8000;
                    end
                    // load any tap not yet written so that the fetch never reads garbage
                    locate_taps(crd, lcrd, j0, j1, lyr, frac);
                    if (!texel_written[lyr * ROW_SLOTS + j0]) begin
                        send_item(ltf_pkg::KIND_LOAD,
                                  pack_item(lyr[3:0], j0[9:0], rand_texel(), $urandom(), $urandom()),
                                  1'b0, '0);
                    end
                    if (!texel_written[lyr * ROW_SLOTS + j1]) begin
                        send_item(ltf_pkg::KIND_LOAD,
                                  pack_item(lyr[3:0], j1[9:0], rand_texel(), $urandom(), $urandom()),
                                  1'b0, '0);
                    end
                    // load fields of a fetch carry junk that the core must ignore
                    send_item(ltf_pkg::KIND_FETCH,
                              pack_item(4'($urandom()), 10'($urandom()), $urandom(), crd, lcrd),
                              1'b0, '0);
                end
            end
        end

        drain_results();
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ltf_pkg.sv
rtl/ltf_addr.sv
rtl/ltf_texel_mem.sv
rtl/ltf_lerp.sv
rtl/ltf_out_fifo.sv
rtl/layered_texture_linear_fetch_core.sv
tb/tb_layered_texture_linear_fetch_core.sv
